>>> sv/tbpc_pkg.sv
`default_nettype none
package tbpc_pkg;

  localparam int CHAN_W  = 3;
  localparam int PER_W   = 16;
  localparam int LVL_W   = 8;
  localparam int PROD_W  = 24;
  localparam int QRAW_W  = 17;
  localparam int RCP_W   = 25;
  localparam int STEP_W  = 5;
  localparam int PINS_W  = 10;

  localparam logic [2:0] CMD_TICK      = 3'd0;
  localparam logic [2:0] CMD_GOTO      = 3'd1;
  localparam logic [2:0] CMD_FULL_UP   = 3'd2;
  localparam logic [2:0] CMD_FULL_DOWN = 3'd3;
  localparam logic [2:0] CMD_READ      = 3'd4;

  localparam logic [CHAN_W-1:0] REG_ENABLED_MASK = 3'd5;

  localparam logic [LVL_W-1:0]  FULL_LEVEL  = 8'd254;
  localparam logic [PER_W-1:0]  UNKNOWN_POS = 16'hFFFF;
  localparam logic [PER_W-1:0]  PERIOD_RST  = 16'd100;
  // ceil(2^32 / 254): exact quotient for dividends below 2^24
  localparam logic [RCP_W-1:0]  RECIP_254   = 25'd16909321;
  localparam logic [STEP_W-1:0] DIV_STEPS   = 5'd24;

  localparam logic [1:0] DIR_STOP = 2'b00;
  localparam logic [1:0] DIR_UP   = 2'b01;
  localparam logic [1:0] DIR_DOWN = 2'b10;

  typedef struct packed {
    logic [2:0]        command;
    logic [CHAN_W-1:0] blind_index;
    logic              all_blinds;
    logic [LVL_W-1:0]  target_level;
  } request_t;

  typedef struct packed {
    logic [PINS_W-1:0] drive_pins;
    logic              position_known;
    logic [LVL_W-1:0]  position_level;
  } result_t;

  typedef enum logic [3:0] {
    ST_IDLE, ST_CHECK, ST_MUL, ST_RCP, ST_WRITE,
    ST_MOVE, ST_DIV_INIT, ST_DIV_RUN, ST_FINISH
  } state_t;

  typedef struct packed {
    logic              latch;
    logic              mul_en;
    logic              rcp_en;
    logic              wr_en;
    logic              move_en;
    logic              div_init;
    logic              div_step;
    logic              finish;
    logic              use_idx;
    logic [CHAN_W-1:0] chan;
  } ctrl_cmd_t;

  typedef struct packed {
    logic is_goto;
  } ctrl_stat_t;

endpackage
`default_nettype wire

>>> sv/timed_blind_position_controller.sv
// Timed blind position controller: five time-estimated blind motor channels.
//
// Request channel: a request is taken at a rising edge with start high and
// busy low; busy then stays high until the request is finished.
// Result channel: done is high for exactly one cycle with the result on
// result (drive pins, position known flag, position level). The receiver
// cannot stall; done drops after that cycle, but result holds until the next finish.
// Config port: cfg_write with cfg_addr 0..4 sets a blind's period, cfg_addr 5
// sets the enabled mask; write only while busy is low.
//
// Sequence: a goto / full up / full down request walks all channels through the
// multiply, reciprocal and write steps of the scaling pipeline; every request then
// moves, runs the restoring divider for the readout level and finishes.
// A new request can be taken in the cycle that done is high, so a new request
// is taken only after the previous one has finished.
// Reset: periods go to 100, mask to 0, positions and targets to unknown,
// calibration flags clear, no result pending.
`default_nettype none
module timed_blind_position_controller #(
  parameter int NUM_BLINDS = 5
) (
  input  wire                          clk,
  input  wire                          rst,
  input  wire                          start,
  output logic                         busy,
  input  tbpc_pkg::request_t           request,
  output tbpc_pkg::result_t            result,
  output logic                         done,
  input  wire                          cfg_write,
  input  wire [tbpc_pkg::CHAN_W-1:0]   cfg_addr,
  input  wire [tbpc_pkg::PER_W-1:0]    cfg_data
);
  import tbpc_pkg::*;

  ctrl_cmd_t  cmd;
  ctrl_stat_t stat;

  // sequencer: latch, per-channel goto walk, move, divide, finish
  tbpc_ctrl #(.NUM_BLINDS(NUM_BLINDS)) u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .busy  (busy),
    .stat  (stat),
    .cmd   (cmd)
  );

  // channel state, scaling pipeline, divider and result register
  tbpc_dp #(.NUM_BLINDS(NUM_BLINDS)) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_addr  (cfg_addr),
    .cfg_data  (cfg_data),
    .request   (request),
    .cmd       (cmd),
    .stat      (stat),
    .result    (result),
    .done      (done)
  );

endmodule
`default_nettype wire

>>> sv/tbpc_ctrl.sv
`default_nettype none
module tbpc_ctrl #(
  parameter int NUM_BLINDS = 5
) (
  input  wire                   clk,
  input  wire                   rst,
  input  wire                   start,
  output logic                  busy,
  input  tbpc_pkg::ctrl_stat_t  stat,
  output tbpc_pkg::ctrl_cmd_t   cmd
);
  import tbpc_pkg::*;

  localparam logic [CHAN_W-1:0] LAST_CHAN = CHAN_W'(NUM_BLINDS - 1);

  state_t             state, state_next;
  logic [CHAN_W-1:0]  chan;
  logic [STEP_W-1:0]  step;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      chan  <= '0;
      step  <= '0;
    end else begin
      state <= state_next;
      if (state == ST_CHECK) chan <= '0;
      else if (state == ST_WRITE) chan <= chan + 1'b1;
      if (state == ST_DIV_INIT) step <= '0;
      else if (state == ST_DIV_RUN) step <= step + 1'b1;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE:     if (start) state_next = ST_CHECK;
      ST_CHECK:    state_next = stat.is_goto ? ST_MUL : ST_MOVE;
      ST_MUL:      state_next = ST_RCP;
      ST_RCP:      state_next = ST_WRITE;
      ST_WRITE:    state_next = (chan == LAST_CHAN) ? ST_MOVE : ST_MUL;
      ST_MOVE:     state_next = ST_DIV_INIT;
      ST_DIV_INIT: state_next = ST_DIV_RUN;
      ST_DIV_RUN:  if (step == DIV_STEPS - 1'b1) state_next = ST_FINISH;
      ST_FINISH:   state_next = ST_IDLE;
      default:     state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd      = '0;
    cmd.chan = chan;
    busy     = (state != ST_IDLE);
    unique case (state)
      ST_IDLE:     cmd.latch    = start;
      ST_MUL:      cmd.mul_en   = 1'b1;
      ST_RCP:      cmd.rcp_en   = 1'b1;
      ST_WRITE:    cmd.wr_en    = 1'b1;
      ST_MOVE:     cmd.move_en  = 1'b1;
      ST_DIV_INIT: begin
        cmd.div_init = 1'b1;
        cmd.use_idx  = 1'b1;
      end
      ST_DIV_RUN:  cmd.div_step = 1'b1;
      ST_FINISH:   begin
        cmd.finish  = 1'b1;
        cmd.use_idx = 1'b1;
      end
      default:     cmd = '0;
    endcase
  end

endmodule
`default_nettype wire

>>> sv/tbpc_dp.sv
`default_nettype none
module tbpc_dp #(
  parameter int NUM_BLINDS = 5
) (
  input  wire                           clk,
  input  wire                           rst,
  input  wire                           cfg_write,
  input  wire [tbpc_pkg::CHAN_W-1:0]    cfg_addr,
  input  wire [tbpc_pkg::PER_W-1:0]     cfg_data,
  input  tbpc_pkg::request_t            request,
  input  tbpc_pkg::ctrl_cmd_t           cmd,
  output tbpc_pkg::ctrl_stat_t          stat,
  output tbpc_pkg::result_t             result,
  output logic                          done
);
  import tbpc_pkg::*;

  logic [PER_W-1:0]  per [NUM_BLINDS];
  logic [PER_W-1:0]  pos [NUM_BLINDS];
  logic [PER_W-1:0]  tgt [NUM_BLINDS];
  logic              cal [NUM_BLINDS];
  logic [4:0]        mask;

  request_t          req;
  logic [LVL_W-1:0]  lvl;
  logic [PROD_W-1:0] prod;
  logic [QRAW_W-1:0] qraw;
  logic [PINS_W-1:0] pins;
  logic [PINS_W-1:0] pins_next;
  logic [QRAW_W-1:0] rem;
  logic [PROD_W-1:0] quo;
  logic [PER_W-1:0]  dvsr;

  // shared read port: goto walk uses the channel counter, readout uses the request index
  logic [CHAN_W-1:0] sel;
  logic [PER_W-1:0]  rd_per, rd_pos;
  logic              sel_ok;

  always_comb begin
    sel    = cmd.use_idx ? req.blind_index : cmd.chan;
    rd_per = '0;
    rd_pos = UNKNOWN_POS;
    sel_ok = 1'b0;
    for (int n = 0; n < NUM_BLINDS; n++) begin
      if (sel == CHAN_W'(n)) begin
        rd_per = per[n];
        rd_pos = pos[n];
        sel_ok = 1'b1;
      end
    end
  end

  assign stat.is_goto = (req.command == CMD_GOTO) || (req.command == CMD_FULL_UP) ||
                        (req.command == CMD_FULL_DOWN);

  // target scaling: round(level * period / 254) through a reciprocal multiply
  logic [48:0]       rcp_full;
  logic [RCP_W-1:0]  q254;
  logic [PROD_W-1:0] rmd_full;
  logic [LVL_W-1:0]  rmd;
  logic [PER_W-1:0]  tgt_new;
  logic              hit;

  assign rcp_full = 49'(prod) * 49'(RECIP_254);
  assign q254     = {qraw, 8'b0} - {7'b0, qraw, 1'b0};
  assign rmd_full = prod - q254[PROD_W-1:0];
  assign rmd      = rmd_full[LVL_W-1:0];
  assign tgt_new  = qraw[PER_W-1:0] + PER_W'({rmd, 1'b0} > {1'b0, FULL_LEVEL});
  assign hit      = req.all_blinds || (req.blind_index == cmd.chan);

  // drive direction of every blind from position, target and calibrate flag
  always_comb begin
    pins_next = '0;
    for (int n = 0; n < NUM_BLINDS; n++) begin
      if (pos[n] < tgt[n] || cal[n]) pins_next[2*n +: 2] = DIR_UP;
      else if (pos[n] > tgt[n]) pins_next[2*n +: 2] = DIR_DOWN;
      else pins_next[2*n +: 2] = DIR_STOP;
    end
  end

  // one restoring divide step
  logic [QRAW_W-1:0] trial;
  logic              fits;
  assign trial = {rem[PER_W-1:0], quo[PROD_W-1]};
  assign fits  = trial >= {1'b0, dvsr};

  // readout rounding
  logic [PROD_W:0]   q_rnd;
  logic [LVL_W-1:0]  lvl_out;
  logic              known;
  always_comb begin
    q_rnd = {1'b0, quo} + (PROD_W+1)'({rem, 1'b0} > {2'b0, dvsr});
    if (dvsr == '0) lvl_out = (rd_pos != '0) ? FULL_LEVEL : '0;
    else if (q_rnd > (PROD_W+1)'(FULL_LEVEL)) lvl_out = FULL_LEVEL;
    else lvl_out = q_rnd[LVL_W-1:0];
    known = sel_ok && (rd_pos != UNKNOWN_POS);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mask <= '0;
      done <= 1'b0;
      for (int n = 0; n < NUM_BLINDS; n++) begin
        per[n] <= PERIOD_RST;
        pos[n] <= UNKNOWN_POS;
        tgt[n] <= UNKNOWN_POS;
        cal[n] <= 1'b0;
      end
    end else begin
      done <= cmd.finish;
      if (cfg_write) begin
        for (int n = 0; n < NUM_BLINDS; n++)
          if (cfg_addr == CHAN_W'(n)) per[n] <= cfg_data;
        if (cfg_addr == REG_ENABLED_MASK) mask <= cfg_data[4:0];
      end
      if (cmd.wr_en && hit) begin
        for (int n = 0; n < NUM_BLINDS; n++) begin
          if (cmd.chan == CHAN_W'(n)) begin
            if (req.command == CMD_FULL_UP) pos[n] <= '0;
            else if (req.command == CMD_FULL_DOWN) pos[n] <= per[n];
            if (mask[n]) begin
              tgt[n] <= tgt_new;
              // seed an unknown position
              if (req.command == CMD_GOTO && pos[n] == UNKNOWN_POS) begin
                if (lvl == FULL_LEVEL) pos[n] <= '0;
                else if (lvl == '0) pos[n] <= per[n];
                else begin
                  pos[n] <= '0;
                  cal[n] <= 1'b1;
                end
              end
            end
          end
        end
      end
      if (cmd.move_en) begin
        for (int n = 0; n < NUM_BLINDS; n++) begin
          if (pos[n] < tgt[n] || cal[n]) begin
            if (req.command == CMD_TICK) begin
              if (pos[n] < per[n] && pos[n] != UNKNOWN_POS) pos[n] <= pos[n] + 1'b1;
              else cal[n] <= 1'b0;
            end
          end else if (pos[n] > tgt[n]) begin
            if (req.command == CMD_TICK && pos[n] != '0 && pos[n] != UNKNOWN_POS)
              pos[n] <= pos[n] - 1'b1;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      req <= request;
      unique case (request.command)
        CMD_FULL_UP:   lvl <= FULL_LEVEL;
        CMD_FULL_DOWN: lvl <= '0;
        default:       lvl <= (request.target_level > FULL_LEVEL) ? FULL_LEVEL
                                                                  : request.target_level;
      endcase
    end
    if (cmd.mul_en) prod <= PROD_W'(lvl) * PROD_W'(rd_per);
    if (cmd.rcp_en) qraw <= rcp_full[48:32];
    if (cmd.move_en) pins <= pins_next;
    if (cmd.div_init) begin
      quo  <= {rd_pos, 8'b0} - {7'b0, rd_pos, 1'b0};
      rem  <= '0;
      dvsr <= rd_per;
    end else if (cmd.div_step) begin
      rem <= fits ? (trial - {1'b0, dvsr}) : trial;
      quo <= {quo[PROD_W-2:0], fits};
    end
    if (cmd.finish) begin
      result.drive_pins     <= pins;
      result.position_known <= known;
      result.position_level <= known ? lvl_out : '0;
    end
  end

endmodule
`default_nettype wire
